>>> hw/rtl/spq_pkg.sv
// Shared types for the sorted priority queue: beats, entries, codes and sequencer states.
package spq_pkg;

	localparam int VAL_W  = 32;
	localparam int PRIO_W = 8;
	localparam int FILL_W = 4;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CMP,
		S_INS_PUT,
		S_DQ_HEAD,
		S_DQ_SHIFT
	} state_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [PRIO_W-1:0]       prio;
	} entry_t;

	typedef struct packed {
		op_t                     opcode;
		logic signed [VAL_W-1:0] item_value;
		logic [PRIO_W-1:0]       item_priority;
	} cmd_t;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] out_value;
		logic [PRIO_W-1:0]       out_priority;
		logic                    out_valid;
		logic [FILL_W-1:0]       fill_level;
	} res_t;

endpackage

>>> hw/rtl/spq_store.sv
// Entry memory: one write port, one read port with registered read data.
module spq_store #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  spq_pkg::entry_t               wr_data,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output spq_pkg::entry_t               rd_data
);

	spq_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hw/rtl/spq_ctrl.sv
// Sequencer: walks the entry memory one slot per cycle for ordered insert and head removal.
module spq_ctrl #(
	parameter int DEPTH = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  spq_pkg::cmd_t                 cmd,
	output logic                          busy,
	output logic                          mem_wr_en,
	output logic [$clog2(DEPTH)-1:0]      mem_wr_addr,
	output spq_pkg::entry_t               mem_wr_data,
	output logic [$clog2(DEPTH)-1:0]      mem_rd_addr,
	input  spq_pkg::entry_t               mem_rd_data,
	output logic                          done,
	output spq_pkg::res_t                 res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	spq_pkg::state_t state_q, state_d;
	spq_pkg::entry_t new_q, new_d;
	spq_pkg::entry_t head_q, head_d;
	logic [AW-1:0]   idx_q, idx_d;
	logic [CW-1:0]   count_q, count_d;
	logic            accept;

	assign busy   = (state_q != spq_pkg::S_IDLE);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		new_q  <= new_d;
		head_q <= head_d;
		idx_q  <= idx_d;
	end

	always_comb begin
		state_d     = state_q;
		new_d       = new_q;
		head_d      = head_q;
		idx_d       = idx_q;
		count_d     = count_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = idx_q;
		mem_wr_data = new_q;
		mem_rd_addr = '0;
		done        = 1'b0;
		res         = '0;
		res.status  = spq_pkg::STAT_OK;

		case (state_q)
			spq_pkg::S_IDLE: begin
				if (accept) begin
					new_d.value = cmd.item_value;
					new_d.prio  = cmd.item_priority;
					if (cmd.opcode == spq_pkg::OP_ENQ) begin
						if (count_q == CW'(DEPTH)) begin
							done       = 1'b1;
							res.status = spq_pkg::STAT_OVERFLOW;
						end else if (count_q == '0) begin
							mem_wr_en        = 1'b1;
							mem_wr_addr      = '0;
							mem_wr_data.value = cmd.item_value;
							mem_wr_data.prio  = cmd.item_priority;
							count_d          = CW'(1);
							done             = 1'b1;
						end else begin
							// scan down from the tail
							idx_d       = AW'(count_q);
							mem_rd_addr = AW'(count_q - CW'(1));
							state_d     = spq_pkg::S_INS_CMP;
						end
					end else begin
						if (count_q == '0) begin
							done       = 1'b1;
							res.status = spq_pkg::STAT_UNDERFLOW;
						end else begin
							mem_rd_addr = '0;
							state_d     = spq_pkg::S_DQ_HEAD;
						end
					end
				end
			end

			spq_pkg::S_INS_CMP: begin
				// strictly greater moves up; equal priority stays ahead
				if (mem_rd_data.prio > new_q.prio) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = idx_q;
					mem_wr_data = mem_rd_data;
					idx_d       = idx_q - AW'(1);
					if (idx_q == AW'(1)) begin
						state_d = spq_pkg::S_INS_PUT;
					end else begin
						mem_rd_addr = idx_q - AW'(2);
					end
				end else begin
					mem_wr_en = 1'b1;
					count_d   = count_q + CW'(1);
					done      = 1'b1;
					state_d   = spq_pkg::S_IDLE;
				end
			end

			spq_pkg::S_INS_PUT: begin
				mem_wr_en = 1'b1;
				count_d   = count_q + CW'(1);
				done      = 1'b1;
				state_d   = spq_pkg::S_IDLE;
			end

			spq_pkg::S_DQ_HEAD: begin
				head_d = mem_rd_data;
				if (count_q == CW'(1)) begin
					count_d          = '0;
					done             = 1'b1;
					res.out_value    = mem_rd_data.value;
					res.out_priority = mem_rd_data.prio;
					res.out_valid    = 1'b1;
					state_d          = spq_pkg::S_IDLE;
				end else begin
					idx_d       = AW'(1);
					mem_rd_addr = AW'(1);
					state_d     = spq_pkg::S_DQ_SHIFT;
				end
			end

			spq_pkg::S_DQ_SHIFT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = idx_q - AW'(1);
				mem_wr_data = mem_rd_data;
				if (CW'(idx_q) + CW'(1) == count_q) begin
					count_d          = count_q - CW'(1);
					done             = 1'b1;
					res.out_value    = head_q.value;
					res.out_priority = head_q.prio;
					res.out_valid    = 1'b1;
					state_d          = spq_pkg::S_IDLE;
				end else begin
					idx_d       = idx_q + AW'(1);
					mem_rd_addr = idx_q + AW'(1);
				end
			end

			default: begin
				state_d = spq_pkg::S_IDLE;
			end
		endcase

		res.fill_level = spq_pkg::FILL_W'(count_d);
	end

endmodule

>>> hw/rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: sequencer, entry memory and result register.
//
// Usage:
//   Command channel: drive cmd and raise start; the beat is taken at a rising
//   edge with start high and busy low. Opcode OP_ENQ inserts item_value with
//   item_priority behind every held entry of lower or equal priority; OP_DEQ
//   removes the entry at the head (lowest priority value, oldest among ties).
//   Result channel: exactly one result beat per command, shown on result for
//   one cycle with done high. The receiver cannot stall; it must take it.
// Sequencing:
//   overflow, underflow or insert into an empty queue: done from idle;
//   insert: read the tail, move up each entry of greater priority value
//   (at most DEPTH - 1), then write the new entry; dequeue: head read, then
//   one slot moved down per cycle. The single memory port pair sets the pace.
// Commands that walk the memory hold busy high until the sequencer is idle.
// A new command may be started the cycle busy drops, while the previous
// result is still on display. Reset empties the queue (count only; entry
// contents are never read before they are written).
module sorted_priority_queue_core #(
	parameter int DEPTH = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  spq_pkg::cmd_t  cmd,
	output logic           done,
	output spq_pkg::res_t  result
);

	localparam int AW = $clog2(DEPTH);

	logic            mem_wr_en;
	logic [AW-1:0]   mem_wr_addr;
	logic [AW-1:0]   mem_rd_addr;
	spq_pkg::entry_t mem_wr_data;
	spq_pkg::entry_t mem_rd_data;

	logic            seq_done;
	spq_pkg::res_t   seq_res;

	logic            done_q;
	spq_pkg::res_t   result_q;

	spq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.busy       (busy),
		.mem_wr_en  (mem_wr_en),
		.mem_wr_addr(mem_wr_addr),
		.mem_wr_data(mem_wr_data),
		.mem_rd_addr(mem_rd_addr),
		.mem_rd_data(mem_rd_data),
		.done       (seq_done),
		.res        (seq_res)
	);

	spq_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data)
	);

	// result register: strobe is control, payload loads only with a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= seq_done;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			result_q <= seq_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
